// ===== hdl/hvcps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and tables of the contactor and precharge sequencer.
package hvcps_pkg;

  // Control states.
  localparam logic [3:0] ST_ERROR        = 4'd0;
  localparam logic [3:0] ST_CLEAR        = 4'd1;
  localparam logic [3:0] ST_DISCHARGE    = 4'd2;
  localparam logic [3:0] ST_STANDBY      = 4'd3;
  localparam logic [3:0] ST_DRV_PRE      = 4'd4;
  localparam logic [3:0] ST_DRV_PRE_DONE = 4'd5;
  localparam logic [3:0] ST_DRIVE        = 4'd6;
  localparam logic [3:0] ST_CHG_PRE      = 4'd7;
  localparam logic [3:0] ST_CHG_PRE_DONE = 4'd8;
  localparam logic [3:0] ST_CHG_TRICKLE  = 4'd9;
  localparam logic [3:0] ST_CHG_CC       = 4'd10;
  localparam logic [3:0] ST_CHG_CV       = 4'd11;
  localparam logic [3:0] ST_UNKNOWN      = 4'd12;

  // Requested modes.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_START  = 3'd1;
  localparam logic [2:0] MODE_RUN    = 3'd2;
  localparam logic [2:0] MODE_CHARGE = 3'd3;
  localparam logic [2:0] MODE_ERROR  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PRECHARGE_WINDOW = 3'd0;
  localparam logic [2:0] CFG_TRICKLE_EXIT     = 3'd1;
  localparam logic [2:0] CFG_CELL_MAX_LIMIT   = 3'd2;
  localparam logic [2:0] CFG_CELL_FULL        = 3'd3;
  localparam logic [2:0] CFG_BUS_DISCHARGED   = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Register values after reset.
  localparam logic [19:0] RST_PRECHARGE_WINDOW = 20'd30000;
  localparam logic [15:0] RST_TRICKLE_EXIT     = 16'd3000;
  localparam logic [15:0] RST_CELL_MAX_LIMIT   = 16'd4280;
  localparam logic [15:0] RST_CELL_FULL        = 16'd4145;
  localparam logic [19:0] RST_BUS_DISCHARGED   = 20'd5000;

  typedef struct packed {
    logic        error_active;
    logic [2:0]  mode_request;
    logic [19:0] pack_voltage_mv;
    logic [19:0] bus_voltage_mv;
    logic [15:0] min_cell_mv;
    logic [15:0] max_cell_mv;
  } tick_req_t;

  typedef struct packed {
    logic [3:0]  present_state;
    logic        air_pos_closed;
    logic        air_neg_closed;
    logic        precharge_closed;
    logic        discharge_closed;
    logic        fault_clear_asserted;
    logic        error_reg_clear;
    logic        balance_msg_valid;
    logic        balance_msg_enable;
    logic [15:0] balance_threshold_mv;
    logic        balancing_on;
  } tick_rsp_t;

  typedef struct packed {
    logic [19:0] precharge_window_mv;
    logic [15:0] trickle_exit_mv;
    logic [15:0] cell_max_limit_mv;
    logic [15:0] cell_full_mv;
    logic [19:0] bus_discharged_mv;
  } cfg_t;

  // Relay drive pattern of a state: bit 0 positive, 1 negative, 2 precharge,
  // 3 discharge.
  function automatic logic [3:0] relay_pattern(input logic [3:0] st);
    logic [3:0] pat;
    case (st)
      ST_DRV_PRE:      pat = 4'd6;
      ST_DRV_PRE_DONE: pat = 4'd7;
      ST_DRIVE:        pat = 4'd3;
      ST_CHG_PRE:      pat = 4'd6;
      ST_CHG_PRE_DONE: pat = 4'd7;
      ST_CHG_TRICKLE:  pat = 4'd3;
      ST_CHG_CC:       pat = 4'd3;
      ST_CHG_CV:       pat = 4'd3;
      default:         pat = 4'd8;
    endcase
    return pat;
  endfunction

endpackage

// ===== hdl/hvcps_channels.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for tick requests and results.
interface hvcps_req_if;
  import hvcps_pkg::*;
  logic      valid;
  logic      ready;
  tick_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hvcps_rsp_if;
  import hvcps_pkg::*;
  logic      valid;
  logic      ready;
  tick_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/hvcps_step.sv =====
`timescale 1ns / 1ps
// Per-tick output decode and next-state logic of the sequencer.
module hvcps_step (
  input  logic [3:0]           state_i,
  input  logic                 balancing_i,
  input  hvcps_pkg::tick_req_t req_i,
  input  hvcps_pkg::cfg_t      cfg_i,
  output hvcps_pkg::tick_rsp_t rsp_o,
  output logic [3:0]           state_o,
  output logic                 balancing_o
);
  import hvcps_pkg::*;

  logic [3:0]  shown;
  logic [3:0]  relays;
  logic [19:0] diff;
  logic        pre_done;
  logic        drive_mode;
  logic        is_charge;
  logic [3:0]  nxt;
  logic        bal;
  logic        msg;
  logic        msg_en;
  logic [15:0] thr;

  assign shown  = (state_i > ST_UNKNOWN) ? ST_UNKNOWN : state_i;
  assign relays = relay_pattern(shown);
  assign diff   = (req_i.pack_voltage_mv > req_i.bus_voltage_mv)
                ? req_i.pack_voltage_mv - req_i.bus_voltage_mv
                : req_i.bus_voltage_mv - req_i.pack_voltage_mv;
  assign pre_done   = diff < cfg_i.precharge_window_mv;
  assign drive_mode = (req_i.mode_request == MODE_START) || (req_i.mode_request == MODE_RUN);
  assign is_charge  = req_i.mode_request == MODE_CHARGE;

  always_comb begin
    nxt    = state_i;
    bal    = balancing_i;
    msg    = 1'b0;
    msg_en = 1'b0;
    thr    = '0;
    if (req_i.error_active) begin
      nxt = ST_ERROR;
    end else begin
      // Leaving balancing through a rest state sends the stop message.
      if (((state_i == ST_ERROR) || (state_i == ST_DISCHARGE) || (state_i == ST_STANDBY))
          && balancing_i) begin
        msg = 1'b1;
        bal = 1'b0;
      end
      case (state_i)
        ST_ERROR: begin
          nxt = (req_i.mode_request == MODE_ERROR) ? ST_CLEAR : ST_ERROR;
        end
        ST_CLEAR: begin
          nxt = ((req_i.mode_request == MODE_IDLE)
                 || (req_i.bus_voltage_mv < cfg_i.bus_discharged_mv)) ? ST_STANDBY : ST_CLEAR;
        end
        ST_DISCHARGE: nxt = ST_STANDBY;
        ST_STANDBY: begin
          if (req_i.mode_request == MODE_START) nxt = ST_DRV_PRE;
          else if (is_charge) nxt = ST_CHG_PRE;
          else nxt = ST_STANDBY;
        end
        ST_DRV_PRE: begin
          if (!drive_mode) nxt = ST_DISCHARGE;
          else nxt = pre_done ? ST_DRV_PRE_DONE : ST_DRV_PRE;
        end
        ST_DRV_PRE_DONE: begin
          if (!drive_mode) nxt = ST_DISCHARGE;
          else nxt = (req_i.mode_request == MODE_RUN) ? ST_DRIVE : ST_DRV_PRE_DONE;
        end
        ST_DRIVE: begin
          nxt = (req_i.mode_request == MODE_RUN) ? ST_DRIVE : ST_DISCHARGE;
        end
        ST_CHG_PRE: begin
          if (!is_charge) begin
            nxt = ST_DISCHARGE;
          end else if (pre_done) begin
            nxt = ST_CHG_PRE_DONE;
            if (!balancing_i) begin
              msg    = 1'b1;
              msg_en = 1'b1;
              thr    = req_i.min_cell_mv;
              bal    = 1'b1;
            end
          end else begin
            nxt = ST_CHG_PRE;
            bal = 1'b0;
          end
        end
        ST_CHG_PRE_DONE: nxt = is_charge ? ST_CHG_TRICKLE : ST_DISCHARGE;
        ST_CHG_TRICKLE: begin
          if (!is_charge) nxt = ST_DISCHARGE;
          else nxt = (req_i.min_cell_mv >= cfg_i.trickle_exit_mv) ? ST_CHG_CC : ST_CHG_TRICKLE;
        end
        ST_CHG_CC: begin
          if (!is_charge || (req_i.max_cell_mv >= cfg_i.cell_max_limit_mv)) nxt = ST_DISCHARGE;
          else nxt = ST_CHG_CC;
        end
        ST_CHG_CV: begin
          if (!is_charge || (req_i.min_cell_mv >= cfg_i.cell_full_mv)) nxt = ST_DISCHARGE;
          else nxt = ST_CHG_CV;
        end
        default: nxt = state_i;
      endcase
    end
  end

  always_comb begin
    rsp_o.present_state        = shown;
    rsp_o.air_pos_closed       = relays[0];
    rsp_o.air_neg_closed       = relays[1];
    rsp_o.precharge_closed     = relays[2];
    rsp_o.discharge_closed     = relays[3];
    rsp_o.fault_clear_asserted = shown == ST_CLEAR;
    rsp_o.error_reg_clear      = shown == ST_CLEAR;
    rsp_o.balance_msg_valid    = msg;
    rsp_o.balance_msg_enable   = msg_en;
    rsp_o.balance_threshold_mv = thr;
    rsp_o.balancing_on         = bal;
  end

  assign state_o     = nxt;
  assign balancing_o = bal;

endmodule

// ===== hdl/hv_contactor_precharge_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Top level of the high-voltage contactor and precharge sequencer.
//
// Each request on tick_in carries one control tick: the error flag, the
// requested mode, pack and bus voltages and the extreme cell voltages. For
// every request exactly one result leaves on tick_out, in order. The result
// shows the relay drives of the state the tick found, plus any cell
// balancing start or stop message that the tick caused.
// A request is captured in an input register; the decode and next-state
// logic then produce its result into the output register, which offers it
// on tick_out. One request is accepted per cycle while the receiver keeps
// taking results; the control state register advances with each request.
// When the receiver stalls, the output register holds its result and the
// input register holds at most one more request; tick_in.ready drops only
// when both are full.
// Reset puts the sequencer in the error state with balancing off, empties
// both registers and loads the threshold registers with their defaults.
// Thresholds are written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must write them only while no request is in flight, which the block
// does not enforce. Indexes beyond the last register are ignored.
module hv_contactor_precharge_sequencer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  hvcps_req_if.sink                        tick_in,
  hvcps_rsp_if.source                      tick_out,
  input  logic                             cfg_we_i,
  input  logic [hvcps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hvcps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import hvcps_pkg::*;

  cfg_t       cfg_q;
  logic       in_vld_q;
  tick_req_t  in_data_q;
  logic       out_vld_q;
  tick_rsp_t  out_data_q;
  logic [3:0] state_q;
  logic       bal_q;

  tick_rsp_t  step_rsp;
  logic [3:0] state_d;
  logic       bal_d;
  logic       advance;
  logic       in_take;

  // A request moves to the output register when that register is free or
  // is being emptied this cycle; the state advances at the same edge.
  assign advance = in_vld_q && (!out_vld_q || tick_out.ready);
  assign tick_in.ready = !in_vld_q || advance;
  assign in_take = tick_in.valid && tick_in.ready;

  assign tick_out.valid = out_vld_q;
  assign tick_out.data  = out_data_q;

  hvcps_step u_step (
    .state_i     (state_q),
    .balancing_i (bal_q),
    .req_i       (in_data_q),
    .cfg_i       (cfg_q),
    .rsp_o       (step_rsp),
    .state_o     (state_d),
    .balancing_o (bal_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.precharge_window_mv <= RST_PRECHARGE_WINDOW;
      cfg_q.trickle_exit_mv     <= RST_TRICKLE_EXIT;
      cfg_q.cell_max_limit_mv   <= RST_CELL_MAX_LIMIT;
      cfg_q.cell_full_mv        <= RST_CELL_FULL;
      cfg_q.bus_discharged_mv   <= RST_BUS_DISCHARGED;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRECHARGE_WINDOW: cfg_q.precharge_window_mv <= cfg_data_i;
        CFG_TRICKLE_EXIT:     cfg_q.trickle_exit_mv     <= cfg_data_i[15:0];
        CFG_CELL_MAX_LIMIT:   cfg_q.cell_max_limit_mv   <= cfg_data_i[15:0];
        CFG_CELL_FULL:        cfg_q.cell_full_mv        <= cfg_data_i[15:0];
        CFG_BUS_DISCHARGED:   cfg_q.bus_discharged_mv   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= ST_ERROR;
      bal_q     <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
        bal_q     <= bal_d;
      end else if (tick_out.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= tick_in.data;
    end
    if (advance) begin
      out_data_q <= step_rsp;
    end
  end

endmodule
